### hdl/bra_pkg.sv
// bra_pkg: operation codes, tcp flag positions and transaction payload types
// for the biflow record aggregator; no dependencies
`timescale 1ns / 1ps

package bra_pkg;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_AGGREGATE = 2'd1,
      OP_READOUT   = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   localparam int unsigned FLAG_SYN_BIT = 1;
   localparam int unsigned FLAG_ACK_BIT = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] in_src_addr;
      logic [31:0] in_dst_addr;
      logic [15:0] in_src_port;
      logic [15:0] in_dst_port;
      logic [31:0] in_time_start;
      logic [31:0] in_time_end;
      logic [63:0] in_octets;
      logic [31:0] in_packets;
      logic [7:0]  in_tcp_flags;
      logic [31:0] time_now;
   } req_payload_type;

   typedef struct packed {
      logic        matched;
      logic        side;
      logic [31:0] out_addr;
      logic [15:0] out_port;
      logic [31:0] out_time_start;
      logic [31:0] out_time_end;
      logic [63:0] out_octets;
      logic [31:0] out_packets;
      logic [7:0]  out_tcp_flags;
      logic [31:0] expire_time;
      logic        last;
   } rsp_payload_type;

endpackage

### hdl/bra_channel_if.sv
// bra_req_if and bra_rsp_if: valid/ready channels carrying the request and
// response payloads; depends on bra_pkg
`timescale 1ns / 1ps

interface bra_req_if;
   import bra_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bra_rsp_if;
   import bra_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/biflow_record_aggregator_unit.sv
// biflow_record_aggregator_unit: single bidirectional connection record with
// load, aggregate and readout; depends on bra_pkg and the channel interfaces
`timescale 1ns / 1ps

// Load and aggregate transactions are taken one per clock while req_if.ready
// is high: the record is updated at the accepting edge and an aggregate result
// appears on rsp_if in the next cycle. A readout places two results (initiator,
// then responder) in the two-entry result register, so the request side stalls
// until the first is taken. req_if.ready follows rsp_if.ready through that
// result register. csr_wr_en writes the expiry timeout (timeout_ff); write only while idle.
module biflow_record_aggregator_unit (
   input  logic        clock,
   input  logic        reset,
   bra_req_if.sink     req_if,
   bra_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import bra_pkg::*;

   logic [15:0] timeout_ff;

   logic [31:0] a_addr_ff, b_addr_ff;
   logic [15:0] a_port_ff, b_port_ff;
   logic [31:0] a_start_ff, a_end_ff, b_start_ff, b_end_ff;
   logic [63:0] a_octets_ff, b_octets_ff;
   logic [31:0] a_packets_ff, b_packets_ff;
   logic [7:0]  a_flags_ff, b_flags_ff;
   logic [31:0] expiry_ff;
   logic        a_seen_ff, b_seen_ff;

   logic [31:0] a_addr_in, b_addr_in;
   logic [15:0] a_port_in, b_port_in;
   logic [31:0] a_start_in, a_end_in, b_start_in, b_end_in;
   logic [63:0] a_octets_in, b_octets_in;
   logic [31:0] a_packets_in, b_packets_in;
   logic [7:0]  a_flags_in, b_flags_in;
   logic [31:0] expiry_in;
   logic        a_seen_in, b_seen_in;

   rsp_payload_type slot0_ff, slot1_ff, slot0_in, slot1_in;
   logic [1:0]      count_ff, count_in;

   req_payload_type rq;
   rsp_payload_type res0, res1;
   logic [1:0]      gen_count;
   logic [1:0]      count_after_pop;
   logic            accept, pop;
   logic            fwd, rev, b_first;
   logic [31:0]     new_exp;

   function automatic rsp_payload_type make_rsp(
      input logic        matched,
      input logic        side,
      input logic [31:0] addr,
      input logic [15:0] port,
      input logic [31:0] t_start,
      input logic [31:0] t_end,
      input logic [63:0] octets,
      input logic [31:0] packets,
      input logic [7:0]  flags,
      input logic [31:0] expire,
      input logic        last
   );
      rsp_payload_type r;
      r.matched        = matched;
      r.side           = side;
      r.out_addr       = addr;
      r.out_port       = port;
      r.out_time_start = t_start;
      r.out_time_end   = t_end;
      r.out_octets     = octets;
      r.out_packets    = packets;
      r.out_tcp_flags  = flags;
      r.expire_time    = expire;
      r.last           = last;
      return r;
   endfunction

   function automatic logic is_opener(input logic [7:0] f);
      return f[FLAG_SYN_BIT] && !f[FLAG_ACK_BIT];
   endfunction

   assign rq     = req_if.data;
   assign pop    = rsp_if.valid && rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;

   // new results always land in slot 0 after any pop in the same cycle
   assign req_if.ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_if.ready);
   assign rsp_if.valid = (count_ff != 2'd0);
   assign rsp_if.data  = slot0_ff;

   assign new_exp = rq.time_now + {16'd0, timeout_ff};

   assign fwd = (rq.in_src_addr == a_addr_ff) && (rq.in_dst_addr == b_addr_ff) &&
                (rq.in_src_port == a_port_ff) && (rq.in_dst_port == b_port_ff);
   assign rev = (rq.in_src_addr == b_addr_ff) && (rq.in_dst_addr == a_addr_ff) &&
                (rq.in_src_port == b_port_ff) && (rq.in_dst_port == a_port_ff);

   always_comb begin
      if (is_opener(a_flags_ff)) begin
         b_first = 1'b0;
      end else if (is_opener(b_flags_ff)) begin
         b_first = 1'b1;
      end else if (a_seen_ff != b_seen_ff) begin
         b_first = b_seen_ff;
      end else begin
         b_first = (a_start_ff > b_start_ff);
      end
   end

   // record update
   always_comb begin
      a_addr_in    = a_addr_ff;
      b_addr_in    = b_addr_ff;
      a_port_in    = a_port_ff;
      b_port_in    = b_port_ff;
      a_start_in   = a_start_ff;
      a_end_in     = a_end_ff;
      b_start_in   = b_start_ff;
      b_end_in     = b_end_ff;
      a_octets_in  = a_octets_ff;
      b_octets_in  = b_octets_ff;
      a_packets_in = a_packets_ff;
      b_packets_in = b_packets_ff;
      a_flags_in   = a_flags_ff;
      b_flags_in   = b_flags_ff;
      expiry_in    = expiry_ff;
      a_seen_in    = a_seen_ff;
      b_seen_in    = b_seen_ff;
      if (accept) begin
         case (op_type'(rq.operation))
            OP_LOAD: begin
               a_addr_in    = rq.in_src_addr;
               a_port_in    = rq.in_src_port;
               b_addr_in    = rq.in_dst_addr;
               b_port_in    = rq.in_dst_port;
               a_start_in   = rq.in_time_start;
               a_end_in     = rq.in_time_end;
               b_start_in   = 32'd0;
               b_end_in     = 32'd0;
               a_octets_in  = rq.in_octets;
               b_octets_in  = 64'd0;
               a_packets_in = rq.in_packets;
               b_packets_in = 32'd0;
               a_flags_in   = rq.in_tcp_flags;
               b_flags_in   = 8'd0;
               expiry_in    = new_exp;
               a_seen_in    = 1'b1;
               b_seen_in    = 1'b0;
            end
            OP_AGGREGATE: begin
               if (fwd) begin
                  expiry_in    = new_exp;
                  a_octets_in  = a_octets_ff + rq.in_octets;
                  a_packets_in = a_packets_ff + rq.in_packets;
                  a_flags_in   = a_flags_ff | rq.in_tcp_flags;
                  // first data on a side takes the times outright
                  a_start_in   = (!a_seen_ff || rq.in_time_start < a_start_ff) ?
                                 rq.in_time_start : a_start_ff;
                  a_end_in     = (!a_seen_ff || rq.in_time_end > a_end_ff) ?
                                 rq.in_time_end : a_end_ff;
                  a_seen_in    = 1'b1;
               end else if (rev) begin
                  expiry_in    = new_exp;
                  b_octets_in  = b_octets_ff + rq.in_octets;
                  b_packets_in = b_packets_ff + rq.in_packets;
                  b_flags_in   = b_flags_ff | rq.in_tcp_flags;
                  b_start_in   = (!b_seen_ff || rq.in_time_start < b_start_ff) ?
                                 rq.in_time_start : b_start_ff;
                  b_end_in     = (!b_seen_ff || rq.in_time_end > b_end_ff) ?
                                 rq.in_time_end : b_end_ff;
                  b_seen_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // results of the accepted transaction
   always_comb begin
      res0      = '0;
      res1      = '0;
      gen_count = 2'd0;
      case (op_type'(rq.operation))
         OP_AGGREGATE: begin
            gen_count = 2'd1;
            if (fwd) begin
               res0 = make_rsp(1'b1, 1'b0, a_addr_ff, a_port_ff, a_start_in, a_end_in,
                               a_octets_in, a_packets_in, a_flags_in, expiry_in, 1'b1);
            end else if (rev) begin
               res0 = make_rsp(1'b1, 1'b1, b_addr_ff, b_port_ff, b_start_in, b_end_in,
                               b_octets_in, b_packets_in, b_flags_in, expiry_in, 1'b1);
            end else begin
               res0.last = 1'b1;
            end
         end
         OP_READOUT: begin
            gen_count = 2'd2;
            if (b_first) begin
               res0 = make_rsp(1'b1, 1'b0, b_addr_ff, b_port_ff, b_start_ff, b_end_ff,
                               b_octets_ff, b_packets_ff, b_flags_ff, expiry_ff, 1'b0);
               res1 = make_rsp(1'b1, 1'b1, a_addr_ff, a_port_ff, a_start_ff, a_end_ff,
                               a_octets_ff, a_packets_ff, a_flags_ff, expiry_ff, 1'b1);
            end else begin
               res0 = make_rsp(1'b1, 1'b0, a_addr_ff, a_port_ff, a_start_ff, a_end_ff,
                               a_octets_ff, a_packets_ff, a_flags_ff, expiry_ff, 1'b0);
               res1 = make_rsp(1'b1, 1'b1, b_addr_ff, b_port_ff, b_start_ff, b_end_ff,
                               b_octets_ff, b_packets_ff, b_flags_ff, expiry_ff, 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   // two-entry result register
   assign count_after_pop = count_ff - {1'b0, pop};

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      count_in = count_after_pop;
      if (accept) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = count_after_pop + gen_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= 16'd0;
         a_addr_ff    <= 32'd0;
         b_addr_ff    <= 32'd0;
         a_port_ff    <= 16'd0;
         b_port_ff    <= 16'd0;
         a_start_ff   <= 32'd0;
         a_end_ff     <= 32'd0;
         b_start_ff   <= 32'd0;
         b_end_ff     <= 32'd0;
         a_octets_ff  <= 64'd0;
         b_octets_ff  <= 64'd0;
         a_packets_ff <= 32'd0;
         b_packets_ff <= 32'd0;
         a_flags_ff   <= 8'd0;
         b_flags_ff   <= 8'd0;
         expiry_ff    <= 32'd0;
         a_seen_ff    <= 1'b0;
         b_seen_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         a_addr_ff    <= a_addr_in;
         b_addr_ff    <= b_addr_in;
         a_port_ff    <= a_port_in;
         b_port_ff    <= b_port_in;
         a_start_ff   <= a_start_in;
         a_end_ff     <= a_end_in;
         b_start_ff   <= b_start_in;
         b_end_ff     <= b_end_in;
         a_octets_ff  <= a_octets_in;
         b_octets_ff  <= b_octets_in;
         a_packets_ff <= a_packets_in;
         b_packets_ff <= b_packets_in;
         a_flags_ff   <= a_flags_in;
         b_flags_ff   <= b_flags_in;
         expiry_ff    <= expiry_in;
         a_seen_ff    <= a_seen_in;
         b_seen_ff    <= b_seen_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

### dv/biflow_record_aggregator_checker.sv
// biflow_record_aggregator_checker: watches the request, response and csr ports of the
// record aggregator, predicts every response and compares it field by field
// depends on bra_pkg and the channel interfaces bra_req_if / bra_rsp_if
`timescale 1ns / 1ps

module biflow_record_aggregator_checker
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bra_req_if          req_if,
   bra_rsp_if          rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] t_first;
      logic [31:0] t_last;
      logic [63:0] octets;
      logic [31:0] packets;
      logic [7:0]  flags;
      logic        seen;
   } flow_side_type;

   flow_side_type   side_a;
   flow_side_type   side_b;
   logic [31:0]     expiry_time;
   logic [15:0]     timeout_sec;
   rsp_payload_type expected_rsp_q[$];

   function automatic logic opens_connection(logic [7:0] f);
      return f[FLAG_SYN_BIT] && !f[FLAG_ACK_BIT];
   endfunction

   function automatic rsp_payload_type side_report(flow_side_type s, logic which,
                                                   logic is_last, logic [31:0] exp_at);
      rsp_payload_type r;
      r.matched        = 1'b1;
      r.side           = which;
      r.out_addr       = s.addr;
      r.out_port       = s.port;
      r.out_time_start = s.t_first;
      r.out_time_end   = s.t_last;
      r.out_octets     = s.octets;
      r.out_packets    = s.packets;
      r.out_tcp_flags  = s.flags;
      r.expire_time    = exp_at;
      r.last           = is_last;
      return r;
   endfunction

   // first data on a side takes its times outright
   function automatic flow_side_type merge_flow(flow_side_type s, req_payload_type p);
      s.octets  = s.octets + p.in_octets;
      s.packets = s.packets + p.in_packets;
      s.flags   = s.flags | p.in_tcp_flags;
      if (!s.seen) begin
         s.t_first = p.in_time_start;
         s.t_last  = p.in_time_end;
      end else begin
         if (p.in_time_start < s.t_first) s.t_first = p.in_time_start;
         if (p.in_time_end > s.t_last) s.t_last = p.in_time_end;
      end
      s.seen = 1'b1;
      return s;
   endfunction

   task automatic predict_record(req_payload_type p);
      logic            fwd;
      logic            rev;
      logic            b_first;
      logic [31:0]     new_expiry;
      rsp_payload_type miss;
      new_expiry = p.time_now + {16'd0, timeout_sec};
      case (op_type'(p.operation))
         OP_LOAD: begin
            side_a         = '0;
            side_a.addr    = p.in_src_addr;
            side_a.port    = p.in_src_port;
            side_a.t_first = p.in_time_start;
            side_a.t_last  = p.in_time_end;
            side_a.octets  = p.in_octets;
            side_a.packets = p.in_packets;
            side_a.flags   = p.in_tcp_flags;
            side_a.seen    = 1'b1;
            side_b         = '0;
            side_b.addr    = p.in_dst_addr;
            side_b.port    = p.in_dst_port;
            expiry_time    = new_expiry;
         end
         OP_AGGREGATE: begin
            fwd = p.in_src_addr == side_a.addr && p.in_dst_addr == side_b.addr &&
                  p.in_src_port == side_a.port && p.in_dst_port == side_b.port;
            rev = p.in_src_addr == side_b.addr && p.in_dst_addr == side_a.addr &&
                  p.in_src_port == side_b.port && p.in_dst_port == side_a.port;
            // a symmetric key matches both ways, forward takes it
            if (fwd) begin
               expiry_time = new_expiry;
               side_a      = merge_flow(side_a, p);
               expected_rsp_q.push_back(side_report(side_a, 1'b0, 1'b1, expiry_time));
            end else if (rev) begin
               expiry_time = new_expiry;
               side_b      = merge_flow(side_b, p);
               expected_rsp_q.push_back(side_report(side_b, 1'b1, 1'b1, expiry_time));
            end else begin
               miss      = '0;
               miss.last = 1'b1;
               expected_rsp_q.push_back(miss);
            end
         end
         OP_READOUT: begin
            if (opens_connection(side_a.flags)) b_first = 1'b0;
            else if (opens_connection(side_b.flags)) b_first = 1'b1;
            else if (side_a.seen != side_b.seen) b_first = side_b.seen;
            else b_first = side_a.t_first > side_b.t_first;
            if (b_first) begin
               expected_rsp_q.push_back(side_report(side_b, 1'b0, 1'b0, expiry_time));
               expected_rsp_q.push_back(side_report(side_a, 1'b1, 1'b1, expiry_time));
            end else begin
               expected_rsp_q.push_back(side_report(side_a, 1'b0, 1'b0, expiry_time));
               expected_rsp_q.push_back(side_report(side_b, 1'b1, 1'b1, expiry_time));
            end
         end
         default: ;
      endcase
   endtask

   function automatic string field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) return $sformatf(" %s exp=%0h act=%0h", name, want, got);
      return "";
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t ns:%s", $time, msg);
   endtask

   task automatic check_response(rsp_payload_type got);
      rsp_payload_type want;
      string           diffs;
      if (expected_rsp_q.size() == 0) begin
         note_failure($sformatf(" response with nothing expected, act=%h", got));
      end else begin
         want  = expected_rsp_q.pop_front();
         diffs = {field_diff("matched", 64'(want.matched), 64'(got.matched)),
                  field_diff("side", 64'(want.side), 64'(got.side)),
                  field_diff("out_addr", 64'(want.out_addr), 64'(got.out_addr)),
                  field_diff("out_port", 64'(want.out_port), 64'(got.out_port)),
                  field_diff("out_time_start", 64'(want.out_time_start),
                             64'(got.out_time_start)),
                  field_diff("out_time_end", 64'(want.out_time_end), 64'(got.out_time_end)),
                  field_diff("out_octets", want.out_octets, got.out_octets),
                  field_diff("out_packets", 64'(want.out_packets), 64'(got.out_packets)),
                  field_diff("out_tcp_flags", 64'(want.out_tcp_flags),
                             64'(got.out_tcp_flags)),
                  field_diff("expire_time", 64'(want.expire_time), 64'(got.expire_time)),
                  field_diff("last", 64'(want.last), 64'(got.last))};
         if (diffs != "") note_failure(diffs);
         checked_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         side_a        = '0;
         side_b        = '0;
         expiry_time   = '0;
         timeout_sec   = '0;
         expected_rsp_q.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (csr_wr_en) timeout_sec = csr_wr_data;
         if (rsp_if.valid && rsp_if.ready) check_response(rsp_if.data);
         if (req_if.valid && req_if.ready) predict_record(req_if.data);
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

### dv/biflow_record_aggregator_unit_test.sv
// biflow_record_aggregator_unit_test: clock, reset and stimulus for the record
// aggregator; depends on bra_pkg, the channel interfaces, the dut and its checker
`timescale 1ns / 1ps

module biflow_record_aggregator_unit_test;
   import bra_pkg::*;

   localparam int ITEMS_PER_PHASE = 460;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int LONG_STALL      = 80;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   bra_req_if req_if ();
   bra_rsp_if rsp_if ();

   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          stall_cnt;
   bit          stall_burst_req;
   int          idle_cycles;
   int          items_sent;
   int          load_cnt;
   int          agg_cnt;
   int          read_cnt;
   int          ignored_cnt;
   logic [15:0] last_timeout;

   biflow_record_aggregator_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   biflow_record_aggregator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic req_payload_type flow(op_type op, logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [31:0] ts, logic [31:0] te,
                                            logic [63:0] oct, logic [31:0] pkt,
                                            logic [7:0] fl, logic [31:0] now);
      req_payload_type p;
      p.operation     = op;
      p.in_src_addr   = sa;
      p.in_dst_addr   = da;
      p.in_src_port   = sp;
      p.in_dst_port   = dp;
      p.in_time_start = ts;
      p.in_time_end   = te;
      p.in_octets     = oct;
      p.in_packets    = pkt;
      p.in_tcp_flags  = fl;
      p.time_now      = now;
      return p;
   endfunction

   // lean toward opener, ack-only and empty flags so every initiator rule gets hit
   function automatic logic [7:0] rand_flags();
      logic [7:0] f;
      case ($urandom_range(3))
         0: f = 8'($urandom_range(255));
         1: f = 8'h02 | (8'($urandom_range(255)) & 8'hED);
         2: f = 8'h00;
         default: f = 8'h10;
      endcase
      return f;
   endfunction

   function automatic req_payload_type random_flow(op_type op, logic [31:0] sa,
                                                   logic [31:0] da, logic [15:0] sp,
                                                   logic [15:0] dp);
      return flow(op, sa, da, sp, dp, $urandom, $urandom, {$urandom, $urandom}, $urandom,
                  rand_flags(), $urandom);
   endfunction

   // called in step with the clock; returns once the dut has accepted the record
   task automatic send_record(req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (op_type'(p.operation))
         OP_LOAD:      load_cnt++;
         OP_AGGREGATE: agg_cnt++;
         OP_READOUT:   read_cnt++;
         default:      ignored_cnt++;
      endcase
      if (op_type'(p.operation) != OP_UNUSED) items_sent++;
   endtask

   task automatic set_expiry_timeout(logic [15:0] value);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      last_timeout  = value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   // a load gives no response, so run SETTLE_CYCLES more after the last response
   task automatic settle_block();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one connection: load, a burst of mixed updates and stray records, then a readout; or one random record
   task automatic run_connection();
      int              n;
      int              pick;
      logic [31:0]     sa;
      logic [31:0]     da;
      logic [15:0]     sp;
      logic [15:0]     dp;
      req_payload_type p;
      if ($urandom_range(9) == 0) begin
         send_record(random_flow(op_type'($urandom_range(3)), $urandom, $urandom,
                                 16'($urandom_range(65535)), 16'($urandom_range(65535))));
         return;
      end
      sa = $urandom;
      da = $urandom;
      sp = 16'($urandom_range(65535));
      dp = 16'($urandom_range(65535));
      if ($urandom_range(15) == 0) begin
         da = sa;
         dp = sp;
      end
      send_record(random_flow(OP_LOAD, sa, da, sp, dp));
      n = $urandom_range(1, 8);
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_record(random_flow(OP_AGGREGATE, sa, da, sp, dp));
         end else if (pick < 75) begin
            send_record(random_flow(OP_AGGREGATE, da, sa, dp, sp));
         end else if (pick < 85) begin
            // near miss: one key field off by a single bit, or a foreign key
            p = random_flow(OP_AGGREGATE, sa, da, sp, dp);
            case ($urandom_range(4))
               0: p.in_src_addr ^= 32'd1 << $urandom_range(31);
               1: p.in_dst_addr ^= 32'd1 << $urandom_range(31);
               2: p.in_src_port ^= 16'd1 << $urandom_range(15);
               3: p.in_dst_port ^= 16'd1 << $urandom_range(15);
               default: p = random_flow(OP_AGGREGATE, $urandom, $urandom,
                                        16'($urandom_range(65535)),
                                        16'($urandom_range(65535)));
            endcase
            send_record(p);
         end else if (pick < 97) begin
            send_record(random_flow(OP_READOUT, $urandom, $urandom,
                                    16'($urandom_range(65535)), 16'($urandom_range(65535))));
         end else begin
            send_record(random_flow(OP_UNUSED, $urandom, $urandom,
                                    16'($urandom_range(65535)), 16'($urandom_range(65535))));
         end
      end
      send_record(random_flow(OP_READOUT, sa, da, sp, dp));
   endtask

   // response side idling and the long back-pressure stretch
   initial begin
      rsp_if.ready = 1'b0;
      stall_cnt    = 0;
      forever begin
         @(posedge clock);
         if (stall_burst_req) begin
            stall_burst_req = 1'b0;
            stall_cnt       = LONG_STALL;
         end
         if (stall_cnt > 0) begin
            rsp_if.ready <= 1'b0;
            stall_cnt--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending_count);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int target;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.data     = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      send_idle_pct   = 21;
      recv_idle_pct   = 86;
      stall_burst_req = 1'b0;
      items_sent      = 0;
      load_cnt        = 0;
      agg_cnt         = 0;
      read_cnt        = 0;
      ignored_cnt     = 0;
      last_timeout    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, expiry timeout still at its reset value
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      // empty record has an all-zero key, so this merges forward as first data
      send_record(flow(OP_AGGREGATE, 0, 0, 0, 0, 32'd5, 32'd9, '1, '1, 8'hFF, '1));
      send_record(random_flow(OP_UNUSED, $urandom, $urandom, 16'hFFFF, 16'h0000));
      send_record(flow(OP_LOAD, '1, 0, '1, 0, 32'd100, 32'd200, '1, '1, 8'h12, '1));
      send_record(flow(OP_AGGREGATE, '1, 0, '1, 0, 32'd50, 32'd300, 64'd2, 32'd3, 8'h01,
                       32'h1234));
      send_record(flow(OP_AGGREGATE, 0, '1, 0, '1, 32'd10, 32'd20, 64'd7, 32'd1, 8'h02,
                       32'h2000));
      send_record(flow(OP_AGGREGATE, 0, '1, 0, '1, 32'd5, 32'd30, '1, '1, 8'h80, 32'h2001));
      send_record(flow(OP_AGGREGATE, '1, 0, '1, 16'd1, 32'd1, 32'd2, 64'd1, 32'd1, 8'h02,
                       32'h2002));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      // both sides open: the A side wins
      send_record(flow(OP_LOAD, 32'h0A000001, 32'h0A000002, 16'd1000, 16'd80, 32'd500,
                       32'd600, 64'd1500, 32'd1, 8'h02, 32'd10));
      send_record(flow(OP_AGGREGATE, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1000, 32'd400,
                       32'd650, 64'd60, 32'd1, 8'h02, 32'd11));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'd12));
      // no opener: earlier start decides, then a tie keeps A first
      send_record(flow(OP_LOAD, 32'h0A000001, 32'h0A000002, 16'd1000, 16'd80, 32'd500,
                       32'd600, 64'd1500, 32'd1, 8'h10, 32'd20));
      send_record(flow(OP_AGGREGATE, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1000, 32'd400,
                       32'd650, 64'd60, 32'd1, 8'h10, 32'd21));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'd22));
      send_record(flow(OP_LOAD, 32'hC0A80001, 32'hC0A80002, 16'd5000, 16'd53, 32'd700,
                       32'd710, 64'd90, 32'd2, 8'h00, 32'd30));
      send_record(flow(OP_AGGREGATE, 32'hC0A80002, 32'hC0A80001, 16'd53, 16'd5000, 32'd700,
                       32'd705, 64'd120, 32'd2, 8'h00, 32'd31));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'd32));
      // only A seen, its late start must not hand the lead to the empty B side
      send_record(flow(OP_LOAD, 32'h7F000001, 32'h7F000002, 16'd1, 16'd2, 32'hFFFFFFF0,
                       '1, 64'd1, 32'd1, 8'h00, 32'd40));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'd41));
      // symmetric key takes the forward merge
      send_record(flow(OP_LOAD, 32'h01020304, 32'h01020304, 16'd443, 16'd443, 32'd900,
                       32'd950, 64'd10, 32'd1, 8'h18, 32'd50));
      send_record(flow(OP_AGGREGATE, 32'h01020304, 32'h01020304, 16'd443, 16'd443, 32'd880,
                       32'd990, 64'd20, 32'd2, 8'h04, 32'd51));
      send_record(flow(OP_AGGREGATE, 32'h01020305, 32'h01020304, 16'd443, 16'd443, 32'd1,
                       32'd2, 64'd1, 32'd1, 8'h01, 32'd52));
      send_record(flow(OP_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'd53));
      settle_block();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 86;
               set_expiry_timeout(16'hFFFF);
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 21;
               set_expiry_timeout(16'h0000);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               set_expiry_timeout(16'($urandom_range(1, 65534)));
               // hold responses off while requests keep coming so the dut backs up
               stall_burst_req = 1'b1;
            end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) run_connection();
         settle_block();
      end

      $display("summary: %0d requests (%0d load, %0d aggregate, %0d readout), %0d ignored,",
               items_sent, load_cnt, agg_cnt, read_cnt, ignored_cnt);
      $display("summary: %0d responses checked; timeouts reset, ffff, 0000, %04h; long stall",
               checked_count, last_timeout);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
